@@ src/xsr_pkg.sv @@
// Package for the xorshift1024* generator: opcodes, constants and the
// command/status structs that pass between controller and datapath.
// No dependencies.
package xsr_pkg;

  // Storage geometry and field widths.
  localparam int STATE_WORDS = 16;
  localparam int IDX_W       = 4;
  localparam int WORD_W      = 64;
  localparam int OP_W        = 2;
  localparam int HALF_W      = WORD_W / 2;

  // Input request payload: word_index in the low bits, then word_value.
  localparam int IN_TDATA_W  = ((IDX_W + WORD_W + 7) / 8) * 8;

  // Xorshift shifts and the odd scrambling multiplier.
  localparam int          SHIFT_A       = 31;
  localparam int          SHIFT_B       = 11;
  localparam int          SHIFT_C       = 30;
  localparam logic [63:0] SCRAMBLE_MULT = 64'd1181783497276652981;

  // Reset value of every state word.
  localparam logic [WORD_W-1:0] WORD_RESET = WORD_W'(1);

  // Request kinds carried on in_tuser.
  typedef enum logic [OP_W-1:0] {
    OP_DRAW  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_SET   = 2'd3
  } op_t;

  // Partial product chosen for the shared 32x32 multiplier.
  typedef enum logic [1:0] {
    MUL_LO_LO = 2'd0,
    MUL_LO_HI = 2'd1,
    MUL_HI_LO = 2'd2
  } mul_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;      // capture the incoming request
    logic     issue;     // read both words, perform write or set position
    logic     mix;       // form the new word, store it, advance position
    logic     mul_en;    // register one partial product
    mul_sel_t mul_sel;
    logic     acc_init;  // accumulator takes the low-by-low product
    logic     acc_add;   // accumulator adds a cross product shifted up
    logic     out_load;  // move the result into the output register
  } xsr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_draw;
    logic out_free;
  } xsr_status_t;

endpackage

@@ src/xorshift1024_star_generator.sv @@
// Channel  | Signals                               | Contents
// in       | in_tvalid, in_tready, in_tuser, in_tdata | op; word_index, word_value
// out      | out_tvalid, out_tready, out_tdata     | fraction, raw_word, read_value, position
//
// A draw goes through memory read, mix and write-back, then three passes
// through one 32x32 multiplier and a final accumulate. Write, read and
// set-position requests skip the mix and multiplier steps.
// Synchronous active-low reset; all words read as one and the position is
// zero right after reset, with no clearing pass.
// A new request is accepted while a finished result waits in the output
// register; a full output register stalls only the end of the next request.
//
// Top level of the xorshift1024* generator; instantiates xsr_ctrl and
// xsr_dpath and depends on xsr_pkg.
module xorshift1024_star_generator #(
  parameter int FRACTION_BITS = 52,
  localparam int OUT_W = ((FRACTION_BITS + 2 * 64 + 4 + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // in_tuser: op
  input  logic [xsr_pkg::OP_W-1:0]       in_tuser,
  // in_tdata: word_index, word_value, zero fill
  input  logic [xsr_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // out_tdata: fraction, raw_word, read_value, position, zero fill
  output logic [OUT_W-1:0]               out_tdata
);
  import xsr_pkg::*;

  xsr_cmd_t    cmd;
  xsr_status_t status;

  // Request sequencing.
  xsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // Storage, mixing, multiplier and output register.
  xsr_dpath #(
    .FRACTION_BITS (FRACTION_BITS),
    .OUT_W         (OUT_W)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Once a request is taken, no other is taken in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while previous request still in work");

  // Mixing only follows the memory read of a draw.
  a_mix_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mix |-> ($past(cmd.issue) && status.is_draw))
    else $error("mix step without preceding draw read");

  // A result is never loaded over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("output register overwritten");

  // The main datapath steps never overlap.
  a_steps_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.issue, cmd.mix, cmd.out_load}))
    else $error("overlapping datapath steps");

endmodule

@@ src/xsr_ctrl.sv @@
// Controller state machine for the xorshift1024* generator.
// Sequences each request through the datapath. Depends on xsr_pkg.
module xsr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  xsr_pkg::xsr_status_t status,
  output xsr_pkg::xsr_cmd_t    cmd
);
  import xsr_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_ISSUE = 8'b0000_0010,
    S_MIX   = 8'b0000_0100,
    S_MUL0  = 8'b0000_1000,
    S_MUL1  = 8'b0001_0000,
    S_MUL2  = 8'b0010_0000,
    S_MUL3  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        state_nxt = status.is_draw ? S_MIX : S_DONE;
      end
      S_MIX: begin
        cmd.mix   = 1'b1;
        state_nxt = S_MUL0;
      end
      S_MUL0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LO_LO;
        state_nxt   = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_LO_HI;
        cmd.acc_init = 1'b1;
        state_nxt    = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_HI_LO;
        cmd.acc_add = 1'b1;
        state_nxt   = S_MUL3;
      end
      S_MUL3: begin
        cmd.acc_add = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ src/xsr_dpath.sv @@
// Datapath for the xorshift1024* generator: state word memory, position,
// xorshift mixing, shared 32x32 multiplier and output register.
// Depends on xsr_pkg; driven by xsr_ctrl.
module xsr_dpath #(
  parameter int FRACTION_BITS = 52,
  parameter int OUT_W         = 184
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [xsr_pkg::OP_W-1:0]       in_tuser,
  input  logic [xsr_pkg::IN_TDATA_W-1:0] in_tdata,
  input  xsr_pkg::xsr_cmd_t              cmd,
  output xsr_pkg::xsr_status_t           status,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [OUT_W-1:0]               out_tdata
);
  import xsr_pkg::*;

  // Captured request.
  op_t               op_r;
  logic [IDX_W-1:0]  idx_r;
  logic [WORD_W-1:0] val_r;

  // Position and state words.
  logic [IDX_W-1:0]       pos_r;
  logic [IDX_W-1:0]       pos_inc;
  logic [WORD_W-1:0]      mem [STATE_WORDS];
  logic [STATE_WORDS-1:0] valid_r;

  // Registered read data, new word, multiplier and accumulator.
  logic [WORD_W-1:0] rd0_r, rd1_r;
  logic [WORD_W-1:0] nw_r, nw;
  logic [WORD_W-1:0] s1;
  logic [WORD_W-1:0] prod_r, acc_r;
  logic [HALF_W-1:0] mul_a, mul_b;

  // Output register.
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  // Memory port control.
  logic [IDX_W-1:0]  raddr0;
  logic              mem_we;
  logic [IDX_W-1:0]  waddr;
  logic [WORD_W-1:0] wdata;

  assign pos_inc = pos_r + IDX_W'(1);

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_t'(in_tuser);
      idx_r <= in_tdata[IDX_W-1:0];
      val_r <= in_tdata[IDX_W +: WORD_W];
    end
  end

  assign status.is_draw  = (op_r == OP_DRAW);
  assign status.out_free = !out_valid_r || out_tready;

  // A read request reads its own index; a draw reads the old position.
  assign raddr0 = (op_r == OP_READ) ? idx_r : pos_r;

  // Single write port shared by the write request and the draw.
  assign mem_we = cmd.mix || (cmd.issue && (op_r == OP_WRITE));
  assign waddr  = cmd.mix ? pos_inc : idx_r;
  assign wdata  = cmd.mix ? nw : val_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
  end

  // Words never written since reset read as one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (mem_we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  // Registered reads at two addresses.
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd0_r <= valid_r[raddr0]  ? mem[raddr0]  : WORD_RESET;
      rd1_r <= valid_r[pos_inc] ? mem[pos_inc] : WORD_RESET;
    end
  end

  // Position updates on set and on draw.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (cmd.mix) begin
      pos_r <= pos_inc;
    end else if (cmd.issue && (op_r == OP_SET)) begin
      pos_r <= val_r[IDX_W-1:0];
    end
  end

  // Xorshift mixing of the old word (rd0) and the next word (rd1).
  assign s1 = rd1_r ^ (rd1_r << SHIFT_A);
  assign nw = s1 ^ rd0_r ^ (s1 >> SHIFT_B) ^ (rd0_r >> SHIFT_C);

  always_ff @(posedge clk) begin
    if (cmd.mix) begin
      nw_r <= nw;
    end
  end

  // Operand selection for the shared multiplier; the high-by-high product
  // falls entirely above bit 63 and is never needed.
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_LO_LO: begin
        mul_a = nw_r[HALF_W-1:0];
        mul_b = SCRAMBLE_MULT[HALF_W-1:0];
      end
      MUL_LO_HI: begin
        mul_a = nw_r[HALF_W-1:0];
        mul_b = SCRAMBLE_MULT[WORD_W-1:HALF_W];
      end
      MUL_HI_LO: begin
        mul_a = nw_r[WORD_W-1:HALF_W];
        mul_b = SCRAMBLE_MULT[HALF_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= WORD_W'(mul_a) * WORD_W'(mul_b);
    end
  end

  // Accumulate the low 64 bits of the product.
  always_ff @(posedge clk) begin
    if (cmd.acc_init) begin
      acc_r <= prod_r;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + {prod_r[HALF_W-1:0], {HALF_W{1'b0}}};
    end
  end

  // Pack the result: fraction, raw_word, read_value, position.
  always_comb begin
    out_data_nxt = '0;
    if (op_r == OP_DRAW) begin
      out_data_nxt[FRACTION_BITS-1:0]        = acc_r[FRACTION_BITS-1:0];
      out_data_nxt[FRACTION_BITS +: WORD_W]  = nw_r;
    end
    if (op_r == OP_READ) begin
      out_data_nxt[FRACTION_BITS + WORD_W +: WORD_W] = rd0_r;
    end
    out_data_nxt[FRACTION_BITS + 2*WORD_W +: IDX_W] = pos_r;
  end

  // Output register; it holds a finished result while the next request
  // is taken in.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ test/tb_xorshift1024_star_generator.sv @@
// Self-checking testbench for the xorshift1024* generator: a directed table
// followed by random request sequences, checked against a predictor or a typed result.
// Depends on xsr_pkg and the xorshift1024_star_generator top level.
module tb_xorshift1024_star_generator;
  import xsr_pkg::*;

  localparam int FRACTION_BITS = 52;
  localparam int OUT_W = ((FRACTION_BITS + 2 * WORD_W + IDX_W + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 1150;
  localparam int REPORT_LIMIT = 10;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AFTER = 400;
  localparam int DRAIN_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 16;

  // One result, laid out so that fraction sits in the lowest bits.
  typedef struct packed {
    logic [IDX_W-1:0]         position;
    logic [WORD_W-1:0]        read_value;
    logic [WORD_W-1:0]        raw_word;
    logic [FRACTION_BITS-1:0] fraction;
  } gen_result_t;

  // One request, with an optional hand-written expected result.
  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  index;
    logic [WORD_W-1:0] value;
    logic              typed;
    gen_result_t       want;
  } gen_request_t;

  // Receiver behavior over one stretch of cycles.
  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_PERIODIC
  } ready_mode_t;

  localparam int NUM_DIRECTED = 20;
  localparam logic [WORD_W-1:0] ONES = '1;

  // Directed requests: op, index, value, typed, {position, read, raw, fraction}.
  localparam gen_request_t DIRECTED [NUM_DIRECTED] = '{
    '{OP_READ,  4'd0,  64'd0,                  1'b1, '{4'd0,  64'd1, 64'd0, 52'd0}},
    '{OP_READ,  4'd15, ONES,                   1'b1, '{4'd0,  64'd1, 64'd0, 52'd0}},
    '{OP_DRAW,  4'd0,  64'd0,                  1'b0, '0},
    '{OP_DRAW,  4'd15, ONES,                   1'b0, '0},
    '{OP_SET,   4'd9,  64'hFFFF_FFFF_FFFF_FFF0, 1'b1, '{4'd0,  64'd0, 64'd0, 52'd0}},
    '{OP_SET,   4'd0,  64'h0000_0000_0000_000F, 1'b1, '{4'd15, 64'd0, 64'd0, 52'd0}},
    '{OP_DRAW,  4'd3,  64'h1234_5678_9ABC_DEF0, 1'b0, '0},
    '{OP_READ,  4'd0,  64'd0,                  1'b0, '0},
    '{OP_WRITE, 4'd0,  ONES,                   1'b1, '{4'd0,  64'd0, 64'd0, 52'd0}},
    '{OP_READ,  4'd0,  64'd0,                  1'b1, '{4'd0,  ONES,  64'd0, 52'd0}},
    '{OP_WRITE, 4'd15, 64'd0,                  1'b1, '{4'd0,  64'd0, 64'd0, 52'd0}},
    '{OP_READ,  4'd15, ONES,                   1'b1, '{4'd0,  64'd0, 64'd0, 52'd0}},
    '{OP_WRITE, 4'd1,  64'h8000_0000_0000_0001, 1'b1, '{4'd0,  64'd0, 64'd0, 52'd0}},
    '{OP_DRAW,  4'd0,  64'd0,                  1'b0, '0},
    '{OP_READ,  4'd1,  64'd0,                  1'b0, '0},
    '{OP_SET,   4'd2,  64'h5A5A_5A5A_5A5A_5A57, 1'b1, '{4'd7,  64'd0, 64'd0, 52'd0}},
    '{OP_WRITE, 4'd7,  64'h0123_4567_89AB_CDEF, 1'b1, '{4'd7,  64'd0, 64'd0, 52'd0}},
    '{OP_DRAW,  4'd0,  64'd0,                  1'b0, '0},
    '{OP_READ,  4'd8,  64'd0,                  1'b0, '0},
    '{OP_DRAW,  4'd8,  ONES,                   1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // in_tuser: op
  logic [OP_W-1:0]       in_tuser;
  // in_tdata: word_index, word_value, zero fill
  logic [IN_TDATA_W-1:0] in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  // out_tdata: fraction, raw_word, read_value, position, zero fill
  logic [OUT_W-1:0]      out_tdata;

  // Predictor state: the sixteen words and the position.
  logic [WORD_W-1:0] gen_words [STATE_WORDS];
  logic [IDX_W-1:0]  gen_position;

  gen_request_t request_list [$];
  gen_result_t  awaited_results [$];
  int           accepted_requests = 0;
  int           results_seen = 0;
  int           mismatches = 0;
  bit           requests_done = 1'b0;

  xorshift1024_star_generator #(
    .FRACTION_BITS(FRACTION_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Free-running clock, period 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the predictor and return the result it causes.
  function automatic gen_result_t next_generator_result(op_t op, logic [IDX_W-1:0] index,
                                                        logic [WORD_W-1:0] value);
    gen_result_t       res;
    logic [IDX_W-1:0]  next_pos;
    logic [WORD_W-1:0] s0;
    logic [WORD_W-1:0] s1;
    logic [WORD_W-1:0] mixed;
    logic [WORD_W-1:0] product;
    res = '0;
    case (op)
      OP_DRAW: begin
        next_pos = gen_position + 4'd1;
        s0 = gen_words[gen_position];
        s1 = gen_words[next_pos];
        s1 = s1 ^ (s1 << SHIFT_A);
        mixed = s1 ^ s0 ^ (s1 >> SHIFT_B) ^ (s0 >> SHIFT_C);
        gen_words[next_pos] = mixed;
        gen_position = next_pos;
        product = mixed * SCRAMBLE_MULT;
        res.raw_word = mixed;
        res.fraction = product[FRACTION_BITS-1:0];
      end
      OP_WRITE: begin
        gen_words[index] = value;
      end
      OP_READ: begin
        res.read_value = gen_words[index];
      end
      default: begin
        // Only the low four bits pick the new position.
        gen_position = value[IDX_W-1:0];
      end
    endcase
    res.position = gen_position;
    return res;
  endfunction

  // Queue a request whose result comes from the predictor.
  function automatic void add_request(op_t op, logic [IDX_W-1:0] index,
                                      logic [WORD_W-1:0] value);
    gen_request_t req;
    req.op = op;
    req.index = index;
    req.value = value;
    req.typed = 1'b0;
    req.want = '0;
    request_list.push_back(req);
  endfunction

  // A state word that is often an edge value.
  function automatic logic [WORD_W-1:0] pick_word();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    if (roll == 2) return WORD_W'(1) << $urandom_range(0, WORD_W - 1);
    return {$urandom, $urandom};
  endfunction

  // Reset, then the end of the run once every request has come back.
  initial begin : run_control
    int waited;
    rst_n <= 1'b0;
    for (int w = 0; w < STATE_WORDS; w++) gen_words[w] = WORD_RESET;
    gen_position = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (requests_done);
    waited = 0;
    while (awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin : run_limit
    #5000000;
    $display("Some tests failed");
    $finish;
  end

  // Build the request list, then send it in bursts with random gaps.
  initial begin : send_requests
    int roll;
    int draws;
    int sent;
    int burst;
    in_tvalid <= 1'b0;
    in_tuser <= OP_DRAW;
    in_tdata <= '0;

    foreach (DIRECTED[i]) request_list.push_back(DIRECTED[i]);

    while (request_list.size() < NUM_DIRECTED + RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 9) begin
        // Reseed: fill every word, pick a position, then draw.
        if (roll < 3) begin
          // Drive the whole state to zero first; draws must then return zero.
          for (int w = 0; w < STATE_WORDS; w++) add_request(OP_WRITE, 4'(w), '0);
          repeat ($urandom_range(2, 5)) add_request(OP_DRAW, 4'($urandom), {$urandom, $urandom});
          add_request(OP_READ, 4'($urandom), {$urandom, $urandom});
        end
        for (int w = 0; w < STATE_WORDS; w++) add_request(OP_WRITE, 4'(w), pick_word());
        add_request(OP_SET, 4'($urandom), {$urandom, $urandom});
        draws = $urandom_range(4, 24);
        repeat (draws) add_request(OP_DRAW, 4'($urandom), {$urandom, $urandom});
      end else if (roll < 65) begin
        repeat ($urandom_range(1, 16)) add_request(OP_DRAW, 4'($urandom), {$urandom, $urandom});
      end else if (roll < 78) begin
        add_request(OP_READ, 4'($urandom), {$urandom, $urandom});
      end else if (roll < 85) begin
        add_request(OP_SET, 4'($urandom), {$urandom, $urandom});
      end else if (roll < 93) begin
        add_request(OP_WRITE, 4'($urandom), pick_word());
      end else begin
        // Noise: any op with any content.
        add_request(op_t'($urandom_range(0, 3)), 4'($urandom), {$urandom, $urandom});
      end
    end

    @(posedge clk);
    while (!rst_n) @(posedge clk);

    sent = 0;
    while (sent < request_list.size()) begin
      burst = $urandom_range(1, 64);
      while (burst > 0 && sent < request_list.size()) begin
        in_tvalid <= 1'b1;
        in_tuser <= request_list[sent].op;
        in_tdata <= {{(IN_TDATA_W - IDX_W - WORD_W){1'b0}},
                     request_list[sent].value, request_list[sent].index};
        do @(posedge clk); while (!in_tready);
        sent++;
        burst--;
      end
      // Gap between bursts, with junk on the data lines.
      if (sent < request_list.size() && $urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        in_tuser <= OP_W'($urandom);
        in_tdata <= {{(IN_TDATA_W - IDX_W - WORD_W){1'b0}}, $urandom, $urandom,
                     4'($urandom)};
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
    requests_done = 1'b1;
  end

  // Result-side ready: random stretches of different patterns, plus one
  // long hold-off so the block fills up and stalls its input.
  initial begin : drive_result_ready
    ready_mode_t mode;
    int          stretch;
    int          phase;
    bit          held_off;
    out_tready <= 1'b0;
    held_off = 1'b0;
    phase = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      mode = ready_mode_t'($urandom_range(0, 3));
      stretch = $urandom_range(4, 80);
      repeat (stretch) begin
        case (mode)
          READY_ALWAYS: out_tready <= 1'b1;
          READY_COIN:   out_tready <= 1'($urandom_range(0, 1));
          READY_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
          default:      out_tready <= (phase % 3 != 0);
        endcase
        phase++;
        @(posedge clk);
      end
      if (!held_off && results_seen >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
    end
  end

  // Predict each accepted request and check each accepted result.
  always @(posedge clk) begin : track_traffic
    gen_result_t expected;
    gen_result_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected = next_generator_result(op_t'(in_tuser), in_tdata[IDX_W-1:0],
                                         in_tdata[IDX_W +: WORD_W]);
        if (accepted_requests < request_list.size() && request_list[accepted_requests].typed)
          expected = request_list[accepted_requests].want;
        awaited_results.push_back(expected);
        accepted_requests++;
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(gen_result_t)-1:0];
        results_seen++;
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("Result %0d arrived with no request outstanding: %h",
                     results_seen, got);
        end else begin
          expected = awaited_results.pop_front();
          if (got.fraction != expected.fraction || got.raw_word != expected.raw_word ||
              got.read_value != expected.read_value || got.position != expected.position) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("Result %0d mismatch:", results_seen);
              $display("  fraction   expected %h actual %h", expected.fraction, got.fraction);
              $display("  raw_word   expected %h actual %h", expected.raw_word, got.raw_word);
              $display("  read_value expected %h actual %h", expected.read_value,
                       got.read_value);
              $display("  position   expected %h actual %h", expected.position, got.position);
            end
          end
        end
      end
    end
  end

endmodule
